[rtl/core/ctsched_pkg.sv]
// Shared types and constants of the cooperative task scheduler.
`timescale 1ns / 1ps

package ctsched_pkg;

    // Default table depth and the most run results that one dispatch gives.
    localparam int TasksDefault = 8;
    localparam int MaxOut       = 8;
    localparam int ResIdxW      = $clog2(MaxOut);
    localparam int ResCntW      = $clog2(MaxOut + 1);

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_TICK     = 3'd1,
        CMD_DISPATCH = 3'd2,
        CMD_DELETE   = 3'd3,
        CMD_REPLACE  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_ADDED      = 3'd0,
        KIND_FULL       = 3'd1,
        KIND_TICK_DONE  = 3'd2,
        KIND_RUN        = 3'd3,
        KIND_NONE_READY = 3'd4,
        KIND_DONE       = 3'd5,
        KIND_BAD_POS    = 3'd6
    } t_kind;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] code_handle;
        logic [15:0] param_handle;
        logic [15:0] release_delay;
        logic [15:0] period;
        logic [7:0]  initial_runs;
        logic [2:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [15:0] task_code;
        logic [15:0] task_param;
        logic [7:0]  pending_runs;
        logic [3:0]  task_count;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PROC,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SLOT_ZERO,
        SLOT_COUNT,
        SLOT_POS_IN,
        SLOT_POS_HELD
    } t_slot_sel;

    typedef struct packed {
        logic      latch;
        logic      add_wr;
        logic      repl_wr;
        logic      walk_init;
        logic      walk_rd;
        logic      walk_proc;
        logic      walk_end;
        logic      push;
        t_kind     push_kind;
        t_slot_sel slot_sel;
        logic      emit;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic pos_bad;
        logic walk_done;
        logic res_none;
        logic emit_last;
    } t_dp_stat;

endpackage

[rtl/core/ctsched_dp.sv]
// Datapath of the task scheduler: task table memory, walk pointers and result buffer.
`timescale 1ns / 1ps

module ctsched_dp import ctsched_pkg::*; #(
    parameter int TASKS = TasksDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW = $clog2(TASKS + 1);

    typedef struct packed {
        logic [15:0] code;
        logic [15:0] param;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  runs;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [15:0] code;
        logic [15:0] param;
        logic [7:0]  runs;
    } t_res;

    t_entry r_mem [TASKS];
    t_entry r_rdata;
    t_res   r_buf [MaxOut];

    t_in_item         r_item;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_wr, n_wr;
    logic [ResCntW-1:0] r_nres, n_nres;
    logic [ResIdxW-1:0] r_e, n_e;
    logic             r_strobe;
    t_out_item        r_out;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          buf_we;
    t_res          buf_wdata;
    t_entry        proc_entry;
    logic          proc_keep;
    logic          proc_push;
    t_res          proc_res;
    logic [2:0]    single_slot;

    // One table entry through the tick, dispatch or delete rule.
    always_comb begin
        proc_entry = r_rdata;
        proc_keep  = 1'b1;
        proc_push  = 1'b0;
        proc_res   = '0;
        case (r_item.cmd)
            CMD_TICK: begin
                if (r_rdata.code != 16'd0) begin
                    if (r_rdata.delay == 16'd0) begin
                        if (r_rdata.runs != 8'hFF) begin
                            proc_entry.runs = r_rdata.runs + 8'd1;
                        end
                        if (r_rdata.period != 16'd0) begin
                            proc_entry.delay = r_rdata.period;
                        end
                    end else begin
                        proc_entry.delay = r_rdata.delay - 16'd1;
                    end
                end
            end
            CMD_DISPATCH: begin
                if (r_nres < ResCntW'(MaxOut) && r_rdata.runs != 8'd0) begin
                    proc_entry.runs = r_rdata.runs - 8'd1;
                    proc_push       = 1'b1;
                    proc_res.kind   = KIND_RUN;
                    proc_res.slot   = 3'(r_wr);
                    proc_res.code   = r_rdata.code;
                    proc_res.param  = r_rdata.param;
                    proc_res.runs   = r_rdata.runs - 8'd1;
                    proc_keep       = (r_rdata.period != 16'd0);
                end
            end
            CMD_DELETE: begin
                proc_keep = (r_rd != CW'(r_item.position));
            end
            default: begin
                proc_keep = 1'b1;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.slot_sel)
            SLOT_COUNT:    single_slot = 3'(r_count);
            SLOT_POS_IN:   single_slot = i_item.position;
            SLOT_POS_HELD: single_slot = r_item.position;
            default:       single_slot = 3'd0;
        endcase
    end

    // Memory write port and result buffer write port.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr[IW-1:0];
        mem_wdata = proc_entry;
        if (i_cmd.add_wr || i_cmd.repl_wr) begin
            mem_we          = 1'b1;
            mem_waddr       = i_cmd.add_wr ? r_count[IW-1:0] : IW'(i_item.position);
            mem_wdata.code  = i_item.code_handle;
            mem_wdata.param = i_item.param_handle;
            mem_wdata.delay = i_item.release_delay;
            mem_wdata.period = i_item.period;
            mem_wdata.runs  = i_item.initial_runs;
        end else if (i_cmd.walk_proc && proc_keep) begin
            mem_we = 1'b1;
        end

        buf_we    = 1'b0;
        buf_wdata = proc_res;
        if (i_cmd.push) begin
            buf_we         = 1'b1;
            buf_wdata      = '0;
            buf_wdata.kind = i_cmd.push_kind;
            buf_wdata.slot = single_slot;
        end else if (i_cmd.walk_proc && proc_push) begin
            buf_we = 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        n_rd    = r_rd;
        n_wr    = r_wr;
        n_nres  = r_nres;
        n_e     = r_e;
        if (i_cmd.add_wr) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.walk_init) begin
            n_rd   = (i_item.cmd == CMD_DELETE) ? CW'(i_item.position) : '0;
            n_wr   = (i_item.cmd == CMD_DELETE) ? CW'(i_item.position) : '0;
            n_nres = '0;
        end
        if (i_cmd.walk_proc) begin
            n_rd = r_rd + CW'(1);
            if (proc_keep) begin
                n_wr = r_wr + CW'(1);
            end
        end
        if (i_cmd.walk_end) begin
            n_count = r_wr;
        end
        if (buf_we) begin
            n_nres = r_nres + ResCntW'(1);
        end
        if (i_cmd.emit) begin
            if (o_stat.emit_last) begin
                n_e    = '0;
                n_nres = '0;
            end else begin
                n_e = r_e + ResIdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_nres   <= '0;
            r_e      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_nres   <= n_nres;
            r_e      <= n_e;
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
        r_wr <= n_wr;
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.walk_rd) begin
            r_rdata <= r_mem[r_rd[IW-1:0]];
        end
        if (buf_we) begin
            r_buf[r_nres[ResIdxW-1:0]] <= buf_wdata;
        end
        if (i_cmd.emit) begin
            r_out.kind         <= r_buf[r_e].kind;
            r_out.slot         <= r_buf[r_e].slot;
            r_out.task_code    <= r_buf[r_e].code;
            r_out.task_param   <= r_buf[r_e].param;
            r_out.pending_runs <= r_buf[r_e].runs;
            r_out.task_count   <= 4'(r_count);
            r_out.last         <= o_stat.emit_last;
        end
    end

    assign o_stat.full      = (r_count == CW'(TASKS));
    assign o_stat.pos_bad   = ({5'd0, i_item.position} >= 8'(r_count));
    assign o_stat.walk_done = (r_rd == r_count);
    assign o_stat.res_none  = (r_nres == '0);
    assign o_stat.emit_last = ((ResCntW'(r_e) + ResCntW'(1)) == r_nres);

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

[rtl/core/ctsched_ctrl.sv]
// Sequencing state machine of the task scheduler.
`timescale 1ns / 1ps

module ctsched_ctrl import ctsched_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_cmd,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EMIT;
                    case (i_cmd)
                        CMD_ADD: begin
                            o_cmd.push = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.push_kind = KIND_FULL;
                            end else begin
                                o_cmd.add_wr    = 1'b1;
                                o_cmd.push_kind = KIND_ADDED;
                                o_cmd.slot_sel  = SLOT_COUNT;
                            end
                        end
                        CMD_TICK, CMD_DISPATCH: begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = ST_READ;
                        end
                        CMD_DELETE, CMD_REPLACE: begin
                            if (i_stat.pos_bad) begin
                                o_cmd.push      = 1'b1;
                                o_cmd.push_kind = KIND_BAD_POS;
                                o_cmd.slot_sel  = SLOT_POS_IN;
                            end else if (i_cmd == CMD_DELETE) begin
                                o_cmd.walk_init = 1'b1;
                                n_state         = ST_READ;
                            end else begin
                                o_cmd.repl_wr   = 1'b1;
                                o_cmd.push      = 1'b1;
                                o_cmd.push_kind = KIND_DONE;
                                o_cmd.slot_sel  = SLOT_POS_IN;
                            end
                        end
                        default: begin
                            o_cmd.push      = 1'b1;
                            o_cmd.push_kind = KIND_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (i_stat.walk_done) begin
                    // The walk is over: settle the count and add any closing result.
                    o_cmd.walk_end = 1'b1;
                    n_state        = ST_EMIT;
                    // The command is held in the datapath; i_cmd is stale here.
                    case (i_stat.res_none)
                        1'b1: begin
                            o_cmd.push = 1'b1;
                        end
                        default: begin
                            o_cmd.push = 1'b0;
                        end
                    endcase
                    o_cmd.push_kind = KIND_NONE_READY;
                    o_cmd.slot_sel  = SLOT_ZERO;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state       = ST_PROC;
                end
            end
            ST_PROC: begin
                o_cmd.walk_proc = 1'b1;
                n_state         = ST_READ;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

[rtl/core/cooperative_task_scheduler_unit.sv]
// Top level of the time-triggered cooperative task scheduler.
`timescale 1ns / 1ps

// Channel       Ports                         Transaction
// command in    start, busy, i_item           start high while busy is low
// result out    o_strobe, o_result            o_strobe high for one cycle
//
// Add, replace, a bad position and an unknown command write their result at
// acceptance and then drive it from the emit state. Tick, dispatch and delete
// walk the task table through its single memory port, in a read state and then
// an update and write-back state per entry visited, then close the walk and
// drive each result in turn from the emit state.
// Reset is synchronous and active low; it empties the table (count zero).
// The receiver cannot stall; busy stays high until the last result is out.

module cooperative_task_scheduler_unit import ctsched_pkg::*; #(
    parameter int TASKS = TasksDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_dp_cmd  ctrl_cmd;

    // The controller sequences the command. It sees the command field only
    // while a transaction is accepted, so it closes every walk the way a
    // dispatch does: a single "none ready" result when no run result was
    // given. Tick and delete walks close with their own result kinds, which
    // are chosen below from the command captured at acceptance.
    ctsched_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.cmd),
        .i_stat  (dp_stat),
        .o_cmd   (ctrl_cmd),
        .o_busy  (busy)
    );

    // Closing result of a walk: tick done, delete done, or none ready when a
    // dispatch gave no run result. The command of the walk is held in r_cmd.
    logic [2:0] r_cmd;

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_item.cmd;
        end
    end

    always_comb begin
        dp_cmd = ctrl_cmd;
        if (ctrl_cmd.walk_end) begin
            case (r_cmd)
                CMD_TICK: begin
                    dp_cmd.push      = 1'b1;
                    dp_cmd.push_kind = KIND_TICK_DONE;
                    dp_cmd.slot_sel  = SLOT_ZERO;
                end
                CMD_DELETE: begin
                    dp_cmd.push      = 1'b1;
                    dp_cmd.push_kind = KIND_DONE;
                    dp_cmd.slot_sel  = SLOT_POS_HELD;
                end
                default: begin
                    dp_cmd.push      = ctrl_cmd.push;
                    dp_cmd.push_kind = KIND_NONE_READY;
                    dp_cmd.slot_sel  = SLOT_ZERO;
                end
            endcase
        end
    end

    ctsched_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
